// ----- rtl/marl_pkg.sv -----
`timescale 1ns / 1ps
package marl_pkg;
    localparam int CLIENTS_DEF = 8;
    localparam int LOG_DEPTH_DEF = 64;
    localparam int CID_W = 3;
    localparam logic [6:0] MAX_REQ_RST = 7'd10;
    localparam logic [23:0] WIN_RST = 24'd60000;

    typedef enum logic [1:0] {
        ALG_FIXED  = 2'd0,
        ALG_LOG    = 2'd1,
        ALG_BUCKET = 2'd2,
        ALG_FIXED3 = 2'd3
    } t_alg;

    localparam logic CFG_MAX_REQ = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    typedef struct packed {
        logic [CID_W-1:0] client;
        logic [1:0]       algorithm;
        logic [31:0]      now_time;
    } t_req;

    typedef struct packed {
        logic        allowed;
        logic [31:0] client_total;
        logic [31:0] client_allowed;
        logic [31:0] client_rejected;
        logic [31:0] global_total;
        logic [31:0] global_allowed;
        logic [31:0] global_rejected;
    } t_rsp;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction
endpackage

// ----- rtl/multi_algorithm_rate_limiter.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake         | Payload
// request   | in        | i_valid / o_stall | i_req (t_req)
// response  | out       | o_valid / i_stall | o_rsp (t_rsp)
// config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// A fixed window transaction steps through S_INIT, S_RD, S_DONE and S_OUT, a token bucket
// one adds S_EVICT, as does a sliding log one, which repeats S_RD and S_EVICT per expired
// entry. The sequencer works around one shared 32-bit subtractor and one log memory port,
// and the next request is taken in the cycle after the response is registered. The log
// memory and per-client algorithm state need no clear; reset clears config, counters and
// seen flags. While a response waits under stall the next request is accepted but held.
module multi_algorithm_rate_limiter #(
    parameter int CLIENTS = marl_pkg::CLIENTS_DEF,
    parameter int LOG_DEPTH = marl_pkg::LOG_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  marl_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output marl_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [0:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import marl_pkg::*;

    localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FW = $clog2(LOG_DEPTH + 1);
    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int AW = $clog2(CLIENTS * LOG_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_INIT, S_RD, S_EVICT, S_DONE, S_OUT} t_state;

    t_state r_state;
    logic [6:0]  r_max;
    logic [23:0] r_win;
    t_req        r_req;
    logic        r_ok;
    logic [CLIENTS-1:0] r_seen;
    logic [31:0] r_wstart [CLIENTS];
    logic [6:0]  r_wcnt [CLIENTS];
    logic [LW-1:0] r_head [CLIENTS];
    logic [FW-1:0] r_fill [CLIENTS];
    logic [30:0] r_tlvl [CLIENTS];
    logic [31:0] r_tlast [CLIENTS];
    logic [31:0] r_ctot [CLIENTS];
    logic [31:0] r_call [CLIENTS];
    logic [31:0] r_crej [CLIENTS];
    logic [31:0] r_gtot, r_gall, r_grej;
    logic [31:0] r_mem [CLIENTS*LOG_DEPTH];
    logic [31:0] r_rd;
    logic [38:0] r_prod;
    t_rsp        r_rsp;
    logic        r_ovalid;

    logic [CW-1:0] cid;
    logic          in_range;
    logic [31:0]   diff;
    logic [31:0]   sub_b;
    logic [30:0]   cap;
    logic [56:0]   lvl;
    logic [56:0]   lvl_c;
    logic [FW-1:0] limit;
    logic          busy;
    logic [LW-1:0] head_nx;
    logic [LW:0]   slot_sum;
    logic [LW-1:0] wr_slot;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign cid = CW'(r_req.client);
    assign in_range = {29'd0, r_req.client} < 32'(CLIENTS);
    assign busy = r_state != S_IDLE;
    assign o_stall = busy;
    assign o_cfg_ready = !busy && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp = r_rsp;
    assign cap = 31'(r_max) * 31'(r_win);
    assign limit = ({25'd0, r_max} < 32'(LOG_DEPTH)) ? FW'(r_max) : FW'(LOG_DEPTH);
    assign head_nx = (32'(r_head[cid]) == 32'(LOG_DEPTH - 1)) ? '0 : r_head[cid] + LW'(1);
    assign slot_sum = (LW+1)'(r_head[cid]) + (LW+1)'(r_fill[cid]);
    assign wr_slot = (slot_sum >= (LW+1)'(LOG_DEPTH)) ?
                     LW'(slot_sum - (LW+1)'(LOG_DEPTH)) : LW'(slot_sum);
    assign rd_addr = AW'(32'(cid) * 32'(LOG_DEPTH) + 32'(r_head[cid]));
    assign wr_addr = AW'(32'(cid) * 32'(LOG_DEPTH) + 32'(wr_slot));

    // Shared subtractor: elapsed time against the selected stamp.
    always_comb begin
        case (r_state)
            S_EVICT: sub_b = r_rd;
            default: sub_b = (t_alg'(r_req.algorithm) == ALG_BUCKET) ?
                             r_tlast[cid] : r_wstart[cid];
        endcase
        diff = r_req.now_time - sub_b;
        lvl = 57'(r_tlvl[cid]) + 57'(r_prod);
        lvl_c = (lvl > 57'(cap)) ? 57'(cap) : lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max <= MAX_REQ_RST;
            r_win <= WIN_RST;
            r_seen <= '0;
            r_ovalid <= 1'b0;
            r_gtot <= '0; r_gall <= '0; r_grej <= '0;
            for (int i = 0; i < CLIENTS; i++) begin
                r_ctot[i] <= '0; r_call[i] <= '0; r_crej[i] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_REQ: r_max <= i_cfg_data[6:0];
                    CFG_WINDOW:  r_win <= i_cfg_data[23:0];
                endcase
                r_seen <= '0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_req <= i_req;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_ok <= 1'b0;
                    if (!in_range) r_state <= S_DONE;
                    else begin
                        if (!r_seen[cid]) begin
                            r_seen[cid] <= 1'b1;
                            r_wstart[cid] <= r_req.now_time;
                            r_wcnt[cid] <= '0;
                            r_head[cid] <= '0;
                            r_fill[cid] <= '0;
                            r_tlvl[cid] <= cap;
                            r_tlast[cid] <= r_req.now_time;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // Prepare memory read and refill product.
                    r_rd <= r_mem[rd_addr];
                    r_prod <= 39'(diff) * 39'(r_max);
                    if (t_alg'(r_req.algorithm) == ALG_LOG) r_state <= S_EVICT;
                    else begin
                        if (t_alg'(r_req.algorithm) == ALG_BUCKET) begin
                            r_tlast[cid] <= r_req.now_time;
                        end else begin
                            if (diff >= 32'(r_win)) begin
                                r_wstart[cid] <= r_req.now_time;
                                r_wcnt[cid] <= (7'd0 < r_max) ? 7'd1 : 7'd0;
                                r_ok <= 7'd0 < r_max;
                            end else if (r_wcnt[cid] < r_max) begin
                                r_wcnt[cid] <= r_wcnt[cid] + 7'd1;
                                r_ok <= 1'b1;
                            end
                        end
                        r_state <= (t_alg'(r_req.algorithm) == ALG_BUCKET) ? S_EVICT : S_DONE;
                    end
                end
                S_EVICT: begin
                    if (t_alg'(r_req.algorithm) == ALG_BUCKET) begin
                        if (lvl_c >= 57'(r_win)) begin
                            r_tlvl[cid] <= 31'(lvl_c - 57'(r_win));
                            r_ok <= 1'b1;
                        end else r_tlvl[cid] <= lvl_c[30:0];
                        r_state <= S_DONE;
                    end else if (r_fill[cid] != '0 && diff > 32'(r_win)) begin
                        r_head[cid] <= head_nx;
                        r_fill[cid] <= r_fill[cid] - FW'(1);
                        r_state <= S_RD;
                    end else begin
                        if (r_fill[cid] < limit) begin
                            r_mem[wr_addr] <= r_req.now_time;
                            r_fill[cid] <= r_fill[cid] + FW'(1);
                            r_ok <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (in_range) begin
                        r_ctot[cid] <= sat_inc(r_ctot[cid]);
                        if (r_ok) r_call[cid] <= sat_inc(r_call[cid]);
                        else r_crej[cid] <= sat_inc(r_crej[cid]);
                    end
                    r_gtot <= sat_inc(r_gtot);
                    if (r_ok) r_gall <= sat_inc(r_gall);
                    else r_grej <= sat_inc(r_grej);
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_rsp.allowed <= r_ok;
                    r_rsp.client_total <= in_range ? r_ctot[cid] : '0;
                    r_rsp.client_allowed <= in_range ? r_call[cid] : '0;
                    r_rsp.client_rejected <= in_range ? r_crej[cid] : '0;
                    r_rsp.global_total <= r_gtot;
                    r_rsp.global_allowed <= r_gall;
                    r_rsp.global_rejected <= r_grej;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> r_state == S_IDLE)
        else $error("config taken while busy");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("response without sequencer");
    a_global_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gtot != 32'hFFFF_FFFF && r_state == S_IDLE) |-> r_gtot == r_gall + r_grej)
        else $error("global counters disagree");
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import marl_pkg::*;

    class rate_scoreboard;
        bit [6:0]  max_req;
        bit [23:0] win_len;
        bit        seen [8];
        bit [31:0] win_start [8];
        bit [6:0]  win_count [8];
        bit [31:0] log_stamp [8][64];
        bit [5:0]  log_head [8];
        bit [6:0]  log_fill [8];
        bit [30:0] tok_level [8];
        bit [31:0] tok_last [8];
        bit [31:0] cl_total [8];
        bit [31:0] cl_allow [8];
        bit [31:0] cl_reject [8];
        bit [31:0] gl_total;
        bit [31:0] gl_allow;
        bit [31:0] gl_reject;
        t_rsp      expected_q [$];
        int        errors;

        function new();
            max_req = MAX_REQ_RST;
            win_len = WIN_RST;
            errors = 0;
            gl_total = 0;
            gl_allow = 0;
            gl_reject = 0;
            for (int i = 0; i < 8; i++) begin
                seen[i] = 0;
                win_start[i] = 0;
                win_count[i] = 0;
                log_head[i] = 0;
                log_fill[i] = 0;
                tok_level[i] = 0;
                tok_last[i] = 0;
                cl_total[i] = 0;
                cl_allow[i] = 0;
                cl_reject[i] = 0;
            end
        endfunction

        function bit [31:0] bump(bit [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void write_reg(bit idx, bit [31:0] data);
            if (idx == CFG_MAX_REQ) begin
                max_req = data[6:0];
            end else begin
                win_len = data[23:0];
            end
            for (int i = 0; i < 8; i++) seen[i] = 0;
        endfunction

        function void note_request(t_req r);
            int unsigned c;
            bit [31:0] now;
            bit ok;
            bit [6:0] lim;
            bit [5:0] slot;
            longint unsigned cap;
            longint unsigned lvl;
            t_rsp e;
            c = r.client;
            now = r.now_time;
            cap = longint'(max_req) * longint'(win_len);
            if (!seen[c]) begin
                seen[c] = 1;
                win_start[c] = now;
                win_count[c] = 0;
                log_head[c] = 0;
                log_fill[c] = 0;
                tok_level[c] = cap[30:0];
                tok_last[c] = now;
            end
            ok = 0;
            if (r.algorithm == ALG_LOG) begin
                lim = (max_req < 7'd64) ? max_req : 7'd64;
                while (log_fill[c] > 0 &&
                       (now - log_stamp[c][log_head[c]]) > {8'd0, win_len}) begin
                    log_head[c] = log_head[c] + 6'd1;
                    log_fill[c] = log_fill[c] - 7'd1;
                end
                if (log_fill[c] < lim) begin
                    slot = log_head[c] + log_fill[c][5:0];
                    log_stamp[c][slot] = now;
                    log_fill[c] = log_fill[c] + 7'd1;
                    ok = 1;
                end
            end else if (r.algorithm == ALG_BUCKET) begin
                lvl = longint'(tok_level[c]) + longint'(now - tok_last[c]) * longint'(max_req);
                if (lvl > cap) lvl = cap;
                tok_last[c] = now;
                if (lvl >= longint'(win_len)) begin
                    lvl = lvl - longint'(win_len);
                    ok = 1;
                end
                tok_level[c] = lvl[30:0];
            end else begin
                if ((now - win_start[c]) >= {8'd0, win_len}) begin
                    win_start[c] = now;
                    win_count[c] = 0;
                end
                if (win_count[c] < max_req) begin
                    win_count[c] = win_count[c] + 7'd1;
                    ok = 1;
                end
            end
            cl_total[c] = bump(cl_total[c]);
            gl_total = bump(gl_total);
            if (ok) begin
                cl_allow[c] = bump(cl_allow[c]);
                gl_allow = bump(gl_allow);
            end else begin
                cl_reject[c] = bump(cl_reject[c]);
                gl_reject = bump(gl_reject);
            end
            e.allowed = ok;
            e.client_total = cl_total[c];
            e.client_allowed = cl_allow[c];
            e.client_rejected = cl_reject[c];
            e.global_total = gl_total;
            e.global_allowed = gl_allow;
            e.global_rejected = gl_reject;
            expected_q = {expected_q, e};
        endfunction

        function void compare_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: mismatch on %s, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_response(t_rsp a);
            t_rsp e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: response with no request outstanding, expected none, actual %0h",
                         $time, a);
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            compare_field("allowed", {31'd0, e.allowed}, {31'd0, a.allowed});
            compare_field("client_total", e.client_total, a.client_total);
            compare_field("client_allowed", e.client_allowed, a.client_allowed);
            compare_field("client_rejected", e.client_rejected, a.client_rejected);
            compare_field("global_total", e.global_total, a.global_total);
            compare_field("global_allowed", e.global_allowed, a.global_allowed);
            compare_field("global_rejected", e.global_rejected, a.global_rejected);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_req        i_req;
    logic        o_valid;
    logic        i_stall;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    rate_scoreboard sb;
    int          idle_cycles;
    int          stall_mode;
    int          stall_age;
    bit [31:0]   client_clock [8];
    bit [23:0]   cur_win;
    int          burst_left;

    multi_algorithm_rate_limiter dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req(i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_req);
            if (o_valid && !i_stall) sb.check_response(o_rsp);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= 5000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_age <= $urandom_range(20, 300);
        end else begin
            stall_age <= stall_age - 1;
        end
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                i_stall <= (stall_age % 7) < 3;
            end
            default: begin
                i_stall <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
            end
        endcase
    end

    task automatic send_request(input t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 25);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_config(input bit idx, input bit [31:0] data);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        if (idx == CFG_WINDOW) cur_win = data[23:0];
    endtask

    task automatic send_item(input int c, input int alg, input bit [31:0] now);
        t_req r;
        r.client = 3'(c);
        r.algorithm = 2'(alg);
        r.now_time = now;
        send_request(r);
    endtask

    task automatic run_random(input int count);
        int c;
        bit [31:0] now;
        for (int n = 0; n < count; n++) begin
            c = $urandom_range(0, 7);
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 15) == 0) begin
                    client_clock[c] = client_clock[c] + cur_win + $urandom_range(1, 3);
                end else begin
                    client_clock[c] = client_clock[c] + $urandom_range(0, (cur_win >> 3) + 2);
                end
                now = client_clock[c];
            end else begin
                now = $urandom;
            end
            send_item(c, $urandom_range(0, 3), now);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_age = 0;
        burst_left = 0;
        cur_win = WIN_RST;
        for (int i = 0; i < 8; i++) client_clock[i] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(0, ALG_FIXED, 32'd0);
        send_item(0, ALG_FIXED3, 32'hFFFF_FFFF);
        send_item(7, ALG_LOG, 32'hFFFF_FFFF);
        send_item(7, ALG_LOG, 32'd59999);
        send_item(7, ALG_LOG, 32'd60000);
        send_item(3, ALG_BUCKET, 32'd100);
        send_item(3, ALG_BUCKET, 32'd100);
        send_item(3, ALG_BUCKET, 32'd99);
        for (int i = 0; i < 11; i++) send_item(5, i % 4, 32'd1000 + i);
        write_config(CFG_MAX_REQ, 32'hFFFF_FF80);
        send_item(1, ALG_FIXED, 32'd5);
        send_item(1, ALG_LOG, 32'd5);
        send_item(1, ALG_BUCKET, 32'd5);
        write_config(CFG_WINDOW, 32'hFF00_0000);
        send_item(2, ALG_BUCKET, 32'd7);
        send_item(2, ALG_LOG, 32'd7);
        write_config(CFG_MAX_REQ, 32'd127);
        for (int i = 0; i < 70; i++) send_item(4, ALG_LOG, 32'd9);
        write_config(CFG_WINDOW, 32'd200);
        for (int i = 0; i < 70; i++) send_item(6, ALG_LOG, 32'hFFFF_FFC0 + i);
        send_item(6, ALG_LOG, 32'd500);

        run_random(120);
        write_config(CFG_MAX_REQ, 32'd0);
        write_config(CFG_WINDOW, 32'd50);
        run_random(100);
        write_config(CFG_MAX_REQ, 32'd1);
        write_config(CFG_WINDOW, 32'd0);
        run_random(100);
        write_config(CFG_MAX_REQ, 32'd64);
        write_config(CFG_WINDOW, 32'hFFFF_FFFF);
        run_random(130);
        write_config(CFG_MAX_REQ, 32'h5A5A_5A05);
        write_config(CFG_WINDOW, 32'h00A5_0000 | 32'd30);
        run_random(130);
        write_config(CFG_MAX_REQ, 32'd3);
        write_config(CFG_WINDOW, 32'd1);
        run_random(110);
        write_config(CFG_MAX_REQ, 32'd100);
        write_config(CFG_WINDOW, 32'd400);
        run_random(150);
        write_config(CFG_MAX_REQ, 32'd10);
        write_config(CFG_WINDOW, 32'd60000);
        run_random(110);

        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/marl_pkg.sv
rtl/multi_algorithm_rate_limiter.sv
test/tb_top.sv
